// ----- src/compass_heading_atan2_unit_macros.svh -----
// assertion macros for the heading unit
`ifndef COMPASS_HEADING_ATAN2_UNIT_MACROS_SVH
`define COMPASS_HEADING_ATAN2_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define CHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define CHA_ASSERT(lbl, clk, rst_n, prop)
`define CHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/cha_pkg.sv -----
`timescale 1ns / 1ps
package cha_pkg;

  localparam int ANGLE_W    = 29;
  localparam int ANGLE_FRAC = 16;
  localparam int GUARD_BITS = 8;
  localparam int TABLE_LEN  = 24;
  localparam int HEADING_W  = 12;

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 29'sd58982400;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 29'sd117964800;
  localparam logic signed [ANGLE_W-1:0] ROUND_HALF   = 29'sd32768;

  localparam logic [HEADING_W-1:0] HEADING_MAX  = 12'd3600;
  localparam logic [HEADING_W-1:0] HEADING_ZERO = 12'd1800;

  typedef struct packed {
    logic valid;
    logic zero;
  } pipe_ctl_t;

  // arctangent of 2^-k in tenths of a degree, 16 fractional bits
  function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 29'sd29491200;
      5'd1:    v = 29'sd17409672;
      5'd2:    v = 29'sd9198793;
      5'd3:    v = 29'sd4669451;
      5'd4:    v = 29'sd2343786;
      5'd5:    v = 29'sd1173036;
      5'd6:    v = 29'sd586661;
      5'd7:    v = 29'sd293348;
      5'd8:    v = 29'sd146676;
      5'd9:    v = 29'sd73339;
      5'd10:   v = 29'sd36669;
      5'd11:   v = 29'sd18335;
      5'd12:   v = 29'sd9167;
      5'd13:   v = 29'sd4584;
      5'd14:   v = 29'sd2292;
      5'd15:   v = 29'sd1146;
      5'd16:   v = 29'sd573;
      5'd17:   v = 29'sd286;
      5'd18:   v = 29'sd143;
      5'd19:   v = 29'sd72;
      5'd20:   v = 29'sd36;
      5'd21:   v = 29'sd18;
      5'd22:   v = 29'sd9;
      5'd23:   v = 29'sd4;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/compass_heading_atan2_unit.sv -----
`timescale 1ns / 1ps
// heading unit: atan2(y, z) in degrees plus 180, as tenths of a degree (0..3600)
// input channel: in_valid_i with y_axis_i and z_axis_i, in_stall_o back to the sender;
//   a transfer happens on a clock edge with in_valid_i high and in_stall_o low
// output channel: out_valid_o with heading_tenths_o, out_stall_i from the receiver
// path: the transfer edge loads the pre-rotation stage, then one cell per iteration (the
//   lesser of CORDIC_STEPS and the table length), then one rounding stage drives out_valid_o
// throughput: one transfer per cycle while in_stall_o is low; every stage is a register with its own
//   valid bit, so empty stages keep filling while a result waits at the output
// stalls: out_stall_i holds the output register; the hold spreads back only
//   through occupied stages, and in_stall_o rises once every stage is full
// both axes zero give 1800, zero y with negative z gives 3600
// reset: asynchronous, active low, empties the pipeline; nothing else is kept
module compass_heading_atan2_unit #(
  parameter int AXIS_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [AXIS_WIDTH-1:0]         y_axis_i,
  input  logic signed [AXIS_WIDTH-1:0]         z_axis_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cha_pkg::HEADING_W-1:0]        heading_tenths_o
);

`include "compass_heading_atan2_unit_macros.svh"

  localparam int VEC_W  = AXIS_WIDTH + cha_pkg::GUARD_BITS + 3;
  localparam int NCELLS = (CORDIC_STEPS < cha_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                               : cha_pkg::TABLE_LEN;

  cha_pkg::pipe_ctl_t                 ctl_s [NCELLS+1];
  logic signed [VEC_W-1:0]            x_s   [NCELLS+1];
  logic signed [VEC_W-1:0]            y_s   [NCELLS+1];
  logic signed [cha_pkg::ANGLE_W-1:0] ang_s [NCELLS+1];
  logic                               hold_s [NCELLS+2];

  cha_prerot #(
    .AXIS_WIDTH(AXIS_WIDTH),
    .VEC_W     (VEC_W)
  ) u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .y_axis_i(y_axis_i),
    .z_axis_i(z_axis_i),
    .hold_i  (hold_s[1]),
    .hold_o  (hold_s[0]),
    .ctl_o   (ctl_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .ang_o   (ang_s[0])
  );

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    cha_cell #(
      .VEC_W(VEC_W),
      .STEP (k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_s[k]),
      .x_i   (x_s[k]),
      .y_i   (y_s[k]),
      .ang_i (ang_s[k]),
      .hold_i(hold_s[k+2]),
      .hold_o(hold_s[k+1]),
      .ctl_o (ctl_s[k+1]),
      .x_o   (x_s[k+1]),
      .y_o   (y_s[k+1]),
      .ang_o (ang_s[k+1])
    );
  end

  cha_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_s[NCELLS]),
    .ang_i    (ang_s[NCELLS]),
    .stall_i  (out_stall_i),
    .hold_o   (hold_s[NCELLS+1]),
    .valid_o  (out_valid_o),
    .heading_o(heading_tenths_o)
  );

  assign in_stall_o = hold_s[0];

  `CHA_ASSERT_IMPL(a_stall_needs_full_out, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `CHA_ASSERT_IMPL(a_heading_in_range, clk_i, rst_ni, out_valid_o, heading_tenths_o <= cha_pkg::HEADING_MAX)
  `CHA_ASSERT_IMPL(a_take_frees_input, clk_i, rst_ni, !out_stall_i, !in_stall_o)
  `CHA_ASSERT(a_reset_empty, clk_i, rst_ni, !$past(rst_ni) |-> !out_valid_o)

endmodule

// ----- src/cha_prerot.sv -----
`timescale 1ns / 1ps
module cha_prerot #(
  parameter int AXIS_WIDTH = 16,
  parameter int VEC_W      = 27
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [AXIS_WIDTH-1:0]           y_axis_i,
  input  logic signed [AXIS_WIDTH-1:0]           z_axis_i,
  input  logic                                   hold_i,
  output logic                                   hold_o,
  output cha_pkg::pipe_ctl_t                     ctl_o,
  output logic signed [VEC_W-1:0]                x_o,
  output logic signed [VEC_W-1:0]                y_o,
  output logic signed [cha_pkg::ANGLE_W-1:0]     ang_o
);

  cha_pkg::pipe_ctl_t                 ctl_q, ctl_d;
  logic signed [VEC_W-1:0]            x_q, x_d, y_q, y_d, xs, ys;
  logic signed [cha_pkg::ANGLE_W-1:0] ang_q, ang_d;

  assign hold_o = ctl_q.valid && hold_i;

  always_comb begin
    xs = VEC_W'(z_axis_i) <<< cha_pkg::GUARD_BITS;
    ys = VEC_W'(y_axis_i) <<< cha_pkg::GUARD_BITS;
    ctl_d.valid = valid_i;
    ctl_d.zero  = (y_axis_i == '0) && (z_axis_i == '0);
    x_d   = xs;
    y_d   = ys;
    ang_d = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x_d   = ys;
        y_d   = -xs;
        ang_d = cha_pkg::QUARTER_TURN;
      end else begin
        x_d   = -ys;
        y_d   = xs;
        ang_d = -cha_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (!hold_o) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_o) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ang_q <= ang_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = ang_q;

endmodule

// ----- src/cha_cell.sv -----
`timescale 1ns / 1ps
module cha_cell #(
  parameter int VEC_W = 27,
  parameter int STEP  = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cha_pkg::pipe_ctl_t                 ctl_i,
  input  logic signed [VEC_W-1:0]            x_i,
  input  logic signed [VEC_W-1:0]            y_i,
  input  logic signed [cha_pkg::ANGLE_W-1:0] ang_i,
  input  logic                               hold_i,
  output logic                               hold_o,
  output cha_pkg::pipe_ctl_t                 ctl_o,
  output logic signed [VEC_W-1:0]            x_o,
  output logic signed [VEC_W-1:0]            y_o,
  output logic signed [cha_pkg::ANGLE_W-1:0] ang_o
);

  localparam logic signed [cha_pkg::ANGLE_W-1:0] ATAN_K = cha_pkg::atan_q16(5'(STEP));

  cha_pkg::pipe_ctl_t                 ctl_q;
  logic signed [VEC_W-1:0]            x_q, x_d, y_q, y_d, x_sh, y_sh;
  logic signed [cha_pkg::ANGLE_W-1:0] ang_q, ang_d;

  assign hold_o = ctl_q.valid && hold_i;

  always_comb begin
    x_sh = x_i >>> STEP;
    y_sh = y_i >>> STEP;
    if (y_i >= 0) begin
      x_d   = x_i + y_sh;
      y_d   = y_i - x_sh;
      ang_d = ang_i + ATAN_K;
    end else begin
      x_d   = x_i - y_sh;
      y_d   = y_i + x_sh;
      ang_d = ang_i - ATAN_K;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (!hold_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_o) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ang_q <= ang_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = ang_q;

endmodule

// ----- src/cha_out.sv -----
`timescale 1ns / 1ps
module cha_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cha_pkg::pipe_ctl_t                 ctl_i,
  input  logic signed [cha_pkg::ANGLE_W-1:0] ang_i,
  input  logic                               stall_i,
  output logic                               hold_o,
  output logic                               valid_o,
  output logic [cha_pkg::HEADING_W-1:0]      heading_o
);

  localparam int RES_W = cha_pkg::ANGLE_W - cha_pkg::ANGLE_FRAC;

  logic                              valid_q;
  logic [cha_pkg::HEADING_W-1:0]     heading_q, heading_d;
  logic signed [cha_pkg::ANGLE_W-1:0] total;
  logic signed [RES_W-1:0]           res;

  assign hold_o = valid_q && stall_i;

  always_comb begin
    total = ang_i + cha_pkg::HALF_TURN + cha_pkg::ROUND_HALF;
    res   = total[cha_pkg::ANGLE_W-1:cha_pkg::ANGLE_FRAC];
    if (ctl_i.zero) begin
      heading_d = cha_pkg::HEADING_ZERO;
    end else if (res < 0) begin
      heading_d = '0;
    end else if (res > $signed({1'b0, cha_pkg::HEADING_MAX})) begin
      heading_d = cha_pkg::HEADING_MAX;
    end else begin
      heading_d = res[cha_pkg::HEADING_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!hold_o) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_o) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o   = valid_q;
  assign heading_o = heading_q;

endmodule
